### rtl/core/oal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg: shared types and constants for the ordered array list engine
// Request and status codes, sizes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package oal_pkg;

    localparam int LIST_DEPTH   = 64;
    localparam int ADDR_W       = $clog2(LIST_DEPTH);
    localparam int CNT_W        = $clog2(LIST_DEPTH + 1);
    localparam int POS_W        = 7;
    localparam int KEY_W        = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 3'd0,
        REQ_DELETE   = 3'd1,
        REQ_FIND     = 3'd2,
        REQ_RETRIEVE = 3'd3,
        REQ_CLEAR    = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_READ_RD,
        S_READ_CAP,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        RD_DOWN,
        RD_UP,
        RD_IDX,
        RD_POS
    } t_rd_sel;

    typedef enum logic {
        WR_MOVE,
        WR_NEW
    } t_wr_sel;

    typedef struct packed {
        logic    latch;
        logic    idx_load_count;
        logic    idx_load_pos;
        logic    idx_load_zero;
        logic    idx_inc;
        logic    idx_dec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    status_load;
        t_status status_code;
        logic    found_set;
        logic    read_cap;
        logic    respond;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             full;
        logic             empty;
        logic             pos_ok;
        logic             ins_pos_ok;
        logic             idx_gt_dst;
        logic             up_in_range;
        logic             idx_lt_count;
        logic             key_match;
    } t_stat;

endpackage

### rtl/core/oal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_ctrl: sequencer for the ordered array list engine
// Decodes each request, steps the datapath through the record moves, the key
// scan or the single read, and closes with one result strobe.
// ----------------------------------------------------------------------------
module oal_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  oal_pkg::t_stat i_stat,
    output oal_pkg::t_cmd  o_cmd
);

    oal_pkg::t_state r_state;
    oal_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != oal_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oal_pkg::S_IDLE: begin
                if (start) n_state = oal_pkg::S_DECODE;
            end
            oal_pkg::S_DECODE: begin
                unique case (i_stat.req_type)
                    oal_pkg::REQ_INSERT: begin
                        if (i_stat.full || !i_stat.ins_pos_ok) n_state = oal_pkg::S_RESP;
                        else                                    n_state = oal_pkg::S_INS_RD;
                    end
                    oal_pkg::REQ_DELETE: begin
                        if (i_stat.empty || !i_stat.pos_ok) n_state = oal_pkg::S_RESP;
                        else                                n_state = oal_pkg::S_DEL_RD;
                    end
                    oal_pkg::REQ_FIND: begin
                        n_state = oal_pkg::S_FIND_RD;
                    end
                    oal_pkg::REQ_RETRIEVE: begin
                        if (i_stat.empty || !i_stat.pos_ok) n_state = oal_pkg::S_RESP;
                        else                                n_state = oal_pkg::S_READ_RD;
                    end
                    default: begin
                        n_state = oal_pkg::S_RESP;
                    end
                endcase
            end
            oal_pkg::S_INS_RD: begin
                if (i_stat.idx_gt_dst) n_state = oal_pkg::S_INS_WR;
                else                   n_state = oal_pkg::S_INS_PUT;
            end
            oal_pkg::S_INS_WR:  n_state = oal_pkg::S_INS_RD;
            oal_pkg::S_INS_PUT: n_state = oal_pkg::S_RESP;
            oal_pkg::S_DEL_RD: begin
                if (i_stat.up_in_range) n_state = oal_pkg::S_DEL_WR;
                else                    n_state = oal_pkg::S_RESP;
            end
            oal_pkg::S_DEL_WR: n_state = oal_pkg::S_DEL_RD;
            oal_pkg::S_FIND_RD: begin
                if (i_stat.idx_lt_count) n_state = oal_pkg::S_FIND_CMP;
                else                     n_state = oal_pkg::S_RESP;
            end
            oal_pkg::S_FIND_CMP: begin
                if (i_stat.key_match) n_state = oal_pkg::S_RESP;
                else                  n_state = oal_pkg::S_FIND_RD;
            end
            oal_pkg::S_READ_RD:  n_state = oal_pkg::S_READ_CAP;
            oal_pkg::S_READ_CAP: n_state = oal_pkg::S_RESP;
            oal_pkg::S_RESP:     n_state = oal_pkg::S_IDLE;
            default:             n_state = oal_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.rd_sel      = oal_pkg::RD_IDX;
        o_cmd.wr_sel      = oal_pkg::WR_MOVE;
        o_cmd.status_code = oal_pkg::ST_OK;
        unique case (r_state)
            oal_pkg::S_IDLE: begin
                o_cmd.latch = start;
            end
            oal_pkg::S_DECODE: begin
                o_cmd.status_load = 1'b1;
                unique case (i_stat.req_type)
                    oal_pkg::REQ_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.status_code = oal_pkg::ST_FULL;
                        end else if (!i_stat.ins_pos_ok) begin
                            o_cmd.status_code = oal_pkg::ST_BADPOS;
                        end else begin
                            o_cmd.idx_load_count = 1'b1;
                        end
                    end
                    oal_pkg::REQ_DELETE, oal_pkg::REQ_RETRIEVE: begin
                        if (i_stat.empty) begin
                            o_cmd.status_code = oal_pkg::ST_EMPTY;
                        end else if (!i_stat.pos_ok) begin
                            o_cmd.status_code = oal_pkg::ST_BADPOS;
                        end else begin
                            o_cmd.idx_load_pos = 1'b1;
                        end
                    end
                    oal_pkg::REQ_FIND: begin
                        o_cmd.status_code   = oal_pkg::ST_NOTFOUND;
                        o_cmd.idx_load_zero = 1'b1;
                    end
                    oal_pkg::REQ_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                    end
                    default: begin
                        o_cmd.status_code = oal_pkg::ST_OK;
                    end
                endcase
            end
            oal_pkg::S_INS_RD: begin
                o_cmd.rd_en  = i_stat.idx_gt_dst;
                o_cmd.rd_sel = oal_pkg::RD_DOWN;
            end
            oal_pkg::S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = oal_pkg::WR_MOVE;
                o_cmd.idx_dec = 1'b1;
            end
            oal_pkg::S_INS_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = oal_pkg::WR_NEW;
                o_cmd.cnt_inc = 1'b1;
            end
            oal_pkg::S_DEL_RD: begin
                o_cmd.rd_en   = i_stat.up_in_range;
                o_cmd.rd_sel  = oal_pkg::RD_UP;
                o_cmd.cnt_dec = !i_stat.up_in_range;
            end
            oal_pkg::S_DEL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = oal_pkg::WR_MOVE;
                o_cmd.idx_inc = 1'b1;
            end
            oal_pkg::S_FIND_RD: begin
                o_cmd.rd_en  = i_stat.idx_lt_count;
                o_cmd.rd_sel = oal_pkg::RD_IDX;
            end
            oal_pkg::S_FIND_CMP: begin
                o_cmd.found_set   = i_stat.key_match;
                o_cmd.status_load = i_stat.key_match;
                o_cmd.status_code = oal_pkg::ST_OK;
                o_cmd.idx_inc     = !i_stat.key_match;
            end
            oal_pkg::S_READ_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = oal_pkg::RD_POS;
            end
            oal_pkg::S_READ_CAP: begin
                o_cmd.read_cap = 1'b1;
            end
            oal_pkg::S_RESP: begin
                o_cmd.respond = 1'b1;
            end
            default: begin
                o_cmd.respond = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/oal_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_dpath: record storage and datapath for the ordered array list engine
// Holds the request, the record memories with a registered read, the entry
// count, the walk index and the result registers.
// ----------------------------------------------------------------------------
module oal_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [oal_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [oal_pkg::POS_W-1:0]   i_position,
    input  logic [oal_pkg::KEY_W-1:0]          i_item_key,
    input  logic [oal_pkg::PAYLOAD_BITS-1:0]   i_item_payload,
    input  oal_pkg::t_cmd                      i_cmd,
    output oal_pkg::t_stat                     o_stat,
    output logic                               o_done,
    output logic [oal_pkg::STATUS_W-1:0]       o_status,
    output logic [oal_pkg::ADDR_W-1:0]         o_found_index,
    output logic [oal_pkg::KEY_W-1:0]          o_read_key,
    output logic [oal_pkg::PAYLOAD_BITS-1:0]   o_read_payload,
    output logic [oal_pkg::CNT_W-1:0]          o_entry_count
);

    localparam int AW = oal_pkg::ADDR_W;
    localparam int CW = oal_pkg::CNT_W;
    localparam int PW = oal_pkg::POS_W;

    logic [oal_pkg::KEY_W-1:0]        r_key_mem [oal_pkg::LIST_DEPTH];
    logic [oal_pkg::PAYLOAD_BITS-1:0] r_pay_mem [oal_pkg::LIST_DEPTH];

    logic [oal_pkg::REQ_W-1:0]        r_type;
    logic [PW-1:0]                    r_pos;
    logic [oal_pkg::KEY_W-1:0]        r_key;
    logic [oal_pkg::PAYLOAD_BITS-1:0] r_pay;
    logic [oal_pkg::KEY_W-1:0]        r_rd_key;
    logic [oal_pkg::PAYLOAD_BITS-1:0] r_rd_pay;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic [CW-1:0]                    r_idx;
    logic [CW-1:0]                    n_idx;
    oal_pkg::t_status                 r_status;
    logic [AW-1:0]                    r_fidx;
    logic [oal_pkg::KEY_W-1:0]        r_rkey;
    logic [oal_pkg::PAYLOAD_BITS-1:0] r_rpay;

    logic [PW-1:0]                    dst;
    logic [CW-1:0]                    rd_ptr;
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic [oal_pkg::KEY_W-1:0]        wr_key;
    logic [oal_pkg::PAYLOAD_BITS-1:0] wr_pay;
    logic [CW:0]                      idx_up;

    // position -1 lands at the front
    assign dst    = r_pos + PW'(1);
    assign idx_up = {1'b0, r_idx} + (CW + 1)'(1);

    assign o_stat.req_type     = r_type;
    assign o_stat.full         = (r_count >= CW'(oal_pkg::LIST_DEPTH));
    assign o_stat.empty        = (r_count == '0);
    assign o_stat.pos_ok       = !r_pos[PW-1] && (CW'(r_pos) < r_count);
    assign o_stat.ins_pos_ok   = (r_pos == '1) || (!r_pos[PW-1] && (CW'(r_pos) < r_count));
    assign o_stat.idx_gt_dst   = (r_idx > CW'(dst));
    assign o_stat.up_in_range  = (idx_up < {1'b0, r_count});
    assign o_stat.idx_lt_count = (r_idx < r_count);
    assign o_stat.key_match    = (r_rd_key == r_key);

    always_comb begin
        unique case (i_cmd.rd_sel)
            oal_pkg::RD_DOWN: rd_ptr = r_idx - CW'(1);
            oal_pkg::RD_UP:   rd_ptr = idx_up[CW-1:0];
            oal_pkg::RD_IDX:  rd_ptr = r_idx;
            oal_pkg::RD_POS:  rd_ptr = CW'(r_pos);
            default:          rd_ptr = r_idx;
        endcase
    end
    assign rd_addr = rd_ptr[AW-1:0];

    always_comb begin
        unique case (i_cmd.wr_sel)
            oal_pkg::WR_NEW: begin
                wr_addr = dst[AW-1:0];
                wr_key  = r_key;
                wr_pay  = r_pay;
            end
            default: begin
                wr_addr = r_idx[AW-1:0];
                wr_key  = r_rd_key;
                wr_pay  = r_rd_pay;
            end
        endcase
    end

    // record memories, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_key_mem[wr_addr] <= wr_key;
            r_pay_mem[wr_addr] <= wr_pay;
        end
        if (i_cmd.rd_en) begin
            r_rd_key <= r_key_mem[rd_addr];
            r_rd_pay <= r_pay_mem[rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        priority if (i_cmd.cnt_clr) n_count = '0;
        else if (i_cmd.cnt_inc)     n_count = r_count + CW'(1);
        else if (i_cmd.cnt_dec)     n_count = r_count - CW'(1);
        else                        n_count = r_count;
    end

    always_comb begin
        n_idx = r_idx;
        priority if (i_cmd.idx_load_count) n_idx = r_count;
        else if (i_cmd.idx_load_pos)       n_idx = CW'(r_pos);
        else if (i_cmd.idx_load_zero)      n_idx = '0;
        else if (i_cmd.idx_inc)            n_idx = idx_up[CW-1:0];
        else if (i_cmd.idx_dec)            n_idx = r_idx - CW'(1);
        else                               n_idx = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            o_done  <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.latch) begin
            r_type <= i_req_type;
            r_pos  <= i_position;
            r_key  <= i_item_key;
            r_pay  <= i_item_payload;
            r_fidx <= '0;
            r_rkey <= '0;
            r_rpay <= '0;
        end
        if (i_cmd.status_load) r_status <= i_cmd.status_code;
        if (i_cmd.found_set)   r_fidx   <= r_idx[AW-1:0];
        if (i_cmd.read_cap) begin
            r_rkey <= r_rd_key;
            r_rpay <= r_rd_pay;
        end
        if (i_cmd.respond) begin
            o_status       <= r_status;
            o_found_index  <= r_fidx;
            o_read_key     <= r_rkey;
            o_read_payload <= r_rpay;
            o_entry_count  <= r_count;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(oal_pkg::LIST_DEPTH))
        else $error("entry count above capacity");

    a_grow_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> !o_stat.full)
        else $error("insert committed on a full list");

    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_entry_count == r_count))
        else $error("reported count differs from held count");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != oal_pkg::ST_OK)) |->
            ((o_found_index == '0) && (o_read_key == '0) && (o_read_payload == '0)))
        else $error("failed request returned data");

    a_idx_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.idx_load_count, i_cmd.idx_load_pos, i_cmd.idx_load_zero,
                  i_cmd.idx_inc, i_cmd.idx_dec}))
        else $error("conflicting index commands");
`endif

endmodule

### rtl/core/ordered_array_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit: ordered list of key and payload records
// Insert, delete, find by key, retrieve and clear on a 64-entry list.
// ----------------------------------------------------------------------------
// Usage: drive a request on i_req_type, i_position, i_item_key and
// i_item_payload and raise start; the request is taken at a clock edge with
// start high and busy low. busy then stays high while the request runs, and
// one result appears on the o_ ports for a single cycle marked by o_done,
// in the same cycle that busy falls. The receiver cannot stall; results must be
// taken when o_done is high. A new request may be issued in the o_done cycle.
// The record store is a memory with one write port and a registered read
// port, and the controller never reads and writes it in one state, so each
// moved or compared record takes a read state and a write or compare state.
// Reset (i_rst_n low, synchronous) empties the list and clears o_done; the
// memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [oal_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [oal_pkg::POS_W-1:0]   i_position,
    input  logic [oal_pkg::KEY_W-1:0]          i_item_key,
    input  logic [oal_pkg::PAYLOAD_BITS-1:0]   i_item_payload,
    output logic                               o_done,
    output logic [oal_pkg::STATUS_W-1:0]       o_status,
    output logic [oal_pkg::ADDR_W-1:0]         o_found_index,
    output logic [oal_pkg::KEY_W-1:0]          o_read_key,
    output logic [oal_pkg::PAYLOAD_BITS-1:0]   o_read_payload,
    output logic [oal_pkg::CNT_W-1:0]          o_entry_count
);

    oal_pkg::t_cmd  cmd;
    oal_pkg::t_stat stat;

    oal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    oal_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_item_key     (i_item_key),
        .i_item_payload (i_item_payload),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_found_index  (o_found_index),
        .o_read_key     (o_read_key),
        .o_read_payload (o_read_payload),
        .o_entry_count  (o_entry_count)
    );

endmodule
